// File: hw/rtl/sgma_pkg.sv
package sgma_pkg;

	// CORDIC in Q30 radians
	localparam int unsigned CordicSteps   = 30;
	localparam int unsigned AngleFracBits = 13;
	localparam int unsigned RoundShift    = 30 - AngleFracBits;
	localparam int unsigned MaxHeight     = 4096;
	localparam int unsigned XyW           = 37;
	localparam int unsigned ZW            = 35;

	localparam logic signed [ZW-1:0] Q30Pi = 35'sd3373259426;

	typedef logic signed [XyW-1:0] cordic_xy_t;
	typedef logic signed [ZW-1:0]  cordic_z_t;

	function automatic cordic_z_t atan_q30(input logic [4:0] i);
		cordic_z_t v;
		case (i)
			5'd0:  v = 35'sd843314857;
			5'd1:  v = 35'sd497837829;
			5'd2:  v = 35'sd263043837;
			5'd3:  v = 35'sd133525159;
			5'd4:  v = 35'sd67021687;
			5'd5:  v = 35'sd33543516;
			5'd6:  v = 35'sd16775851;
			5'd7:  v = 35'sd8388437;
			5'd8:  v = 35'sd4194283;
			5'd9:  v = 35'sd2097149;
			default: v = cordic_z_t'(35'sd1 <<< (30 - i));
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/sobel_gradient_magnitude_angle_unit.sv
// Streaming 3x3 Sobel gradient unit. Grey pixels enter in raster order on the
// s_axis side, one word each; tuser=1 marks a pad word sent to flush a frame
// (pixel ignored, enters the line buffers as 0). Each word gives at most one
// result word on m_axis: magnitude floor(sqrt(gx^2+gy^2)) saturated at 255 and
// direction atan2(gy,gx) in radians * 2^13 (two's complement), both zero on
// border pixels; tlast marks the frame's final pixel. Results lag input by
// frame_width+1 words, so a frame is followed by frame_width+1 pad words.
// Sequence: a word that gives no result takes a buffer read and a window
// shift, a border result adds done, and an interior pixel takes read, shift,
// gradient, setup, 30 CORDIC vectoring iterations on one shared shift/add unit,
// round and done; the 8-step integer square root runs alongside the first 8
// CORDIC iterations.
// s_axis_tready is high only while the sequencer is idle; the output register
// lets the next word in while a result still waits. Writing frame_width or
// frame_height (index 0 / 1) restarts the frame; write only while idle.
// Line buffers are not cleared; unwritten entries only reach border results.
module sobel_gradient_magnitude_angle_unit #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] pixel_value
	input  logic        s_axis_tuser,  // pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] magnitude, [23:8] direction
	output logic        m_axis_tlast,  // frame_last
	input  logic        cfg_we,
	input  logic        cfg_index,     // 0 frame_width, 1 frame_height
	input  logic [12:0] cfg_data
);

	localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RegFrameWidth  = 0;
	localparam int unsigned RegFrameHeight = 1;

	typedef enum logic [2:0] {
		S_IDLE, S_SHIFT, S_GRAD, S_SQ, S_CORD, S_ROUND, S_DONE
	} state_t;

	state_t state_q;

	logic [10:0] frame_width_q;
	logic [12:0] frame_height_q;

	// effective sizes
	logic [13:0] w_eff;
	logic [13:0] h_eff;
	always_comb begin
		if (frame_width_q < 11'd3)
			w_eff = 14'd3;
		else if ({3'd0, frame_width_q} > 14'(MAX_WIDTH))
			w_eff = 14'(MAX_WIDTH);
		else
			w_eff = {3'd0, frame_width_q};
		if (frame_height_q < 13'd3)
			h_eff = 14'd3;
		else if ({1'b0, frame_height_q} > 14'(sgma_pkg::MaxHeight))
			h_eff = 14'(sgma_pkg::MaxHeight);
		else
			h_eff = {1'b0, frame_height_q};
	end

	// line buffers
	logic [7:0] top_mem [MAX_WIDTH];
	logic [7:0] mid_mem [MAX_WIDTH];
	logic [7:0] top_rd_q, mid_rd_q, px_q;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [12:0]   in_row_q, out_row_q;
	logic [7:0]    win_q [9];

	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (accept) begin
			top_rd_q <= top_mem[in_col_q];
			mid_rd_q <= mid_mem[in_col_q];
			px_q     <= s_axis_tuser ? 8'd0 : s_axis_tdata;
		end
		if (state_q == S_SHIFT) begin
			top_mem[in_col_q] <= mid_rd_q;
			mid_mem[in_col_q] <= px_q;
		end
	end

	// raster bookkeeping
	logic emit, interior, last;
	always_comb begin
		emit = (in_row_q >= 13'd2) || (in_row_q == 13'd1 && in_col_q != '0);
		interior = (out_row_q != 13'd0) && ({1'b0, out_row_q} + 14'd1 < h_eff)
			&& (out_col_q != '0) && (14'(out_col_q) + 14'd1 < w_eff);
		last = ({1'b0, out_row_q} + 14'd1 >= h_eff) && (14'(out_col_q) + 14'd1 >= w_eff);
	end

	// Sobel sums on the shifted window
	logic signed [10:0] gx, gy;
	always_comb begin
		gx = (11'(win_q[2]) + (11'(win_q[5]) << 1) + 11'(win_q[8]))
			- (11'(win_q[0]) + (11'(win_q[3]) << 1) + 11'(win_q[6]));
		gy = (11'(win_q[6]) + (11'(win_q[7]) << 1) + 11'(win_q[8]))
			- (11'(win_q[0]) + (11'(win_q[1]) << 1) + 11'(win_q[2]));
	end

	logic signed [10:0] gx_q, gy_q;
	logic [21:0] sum_sq;
	assign sum_sq = (22'(gx_q) * 22'(gx_q)) + (22'(gy_q) * 22'(gy_q));

	// shared CORDIC / sqrt datapath
	sgma_pkg::cordic_xy_t x_q, y_q, x_sh, y_sh;
	sgma_pkg::cordic_z_t  z_q;
	logic [4:0]  step_q;
	logic [16:0] s_q, r_q, sq_bit, sq_trial;
	logic        sat_q, zero_q, last_q;
	logic [7:0]  res_mag_q;
	logic [15:0] res_dir_q;
	sgma_pkg::cordic_z_t z_abs;
	logic [sgma_pkg::ZW-1:0] z_rnd;

	always_comb begin
		x_sh     = x_q >>> step_q;
		y_sh     = y_q >>> step_q;
		sq_bit   = 17'd1 << (5'd14 - {step_q[3:0], 1'b0});
		sq_trial = r_q + sq_bit;
		z_abs    = z_q[sgma_pkg::ZW-1] ? -z_q : z_q;
		z_rnd    = (z_abs + (sgma_pkg::ZW'(1) << (sgma_pkg::RoundShift - 1)))
			>> sgma_pkg::RoundShift;
	end

	logic m_valid_q, m_last_q;
	logic [23:0] m_data_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			frame_width_q  <= 11'd1024;
			frame_height_q <= 13'd1024;
			in_col_q       <= '0;
			in_row_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			m_valid_q      <= 1'b0;
			for (int k = 0; k < 9; k++)
				win_q[k] <= 8'd0;
		end else begin
			// a waiting word leaves unless a new one is loaded in its place
			if (m_valid_q && m_axis_tready && state_q != S_DONE)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == 1'(RegFrameWidth))
							frame_width_q <= cfg_data[10:0];
						else
							frame_height_q <= cfg_data;
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end
					if (accept)
						state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					for (int k = 0; k < 3; k++) begin
						win_q[3*k]   <= win_q[3*k+1];
						win_q[3*k+1] <= win_q[3*k+2];
					end
					win_q[2] <= top_rd_q;
					win_q[5] <= mid_rd_q;
					win_q[8] <= px_q;
					// final pixel of the frame restarts the input raster too
					if (emit && last) begin
						in_col_q <= '0;
						in_row_q <= '0;
					end else if (14'(in_col_q) + 14'd1 >= w_eff) begin
						in_col_q <= '0;
						if (in_row_q != 13'd8191)
							in_row_q <= in_row_q + 13'd1;
					end else begin
						in_col_q <= in_col_q + CW'(1);
					end
					last_q     <= last;
					res_mag_q  <= 8'd0;
					res_dir_q  <= 16'd0;
					if (emit) begin
						if (last) begin
							out_col_q <= '0;
							out_row_q <= '0;
						end else if (14'(out_col_q) + 14'd1 >= w_eff) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 13'd1;
						end else begin
							out_col_q <= out_col_q + CW'(1);
						end
						state_q <= interior ? S_GRAD : S_DONE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_GRAD: begin
					gx_q    <= gx;
					gy_q    <= gy;
					state_q <= S_SQ;
				end
				S_SQ: begin
					sat_q  <= sum_sq >= 22'd65536;
					s_q    <= sum_sq[16:0];
					r_q    <= '0;
					zero_q <= (gx_q == 11'sd0) && (gy_q == 11'sd0);
					step_q <= '0;
					if (gx_q < 0) begin
						x_q <= -(sgma_pkg::cordic_xy_t'(gx_q) <<< 24);
						y_q <= -(sgma_pkg::cordic_xy_t'(gy_q) <<< 24);
						z_q <= (gy_q >= 0) ? sgma_pkg::Q30Pi : -sgma_pkg::Q30Pi;
					end else begin
						x_q <= sgma_pkg::cordic_xy_t'(gx_q) <<< 24;
						y_q <= sgma_pkg::cordic_xy_t'(gy_q) <<< 24;
						z_q <= '0;
					end
					state_q <= S_CORD;
				end
				S_CORD: begin
					if (y_q > 0) begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						z_q <= z_q + sgma_pkg::atan_q30(step_q);
					end else begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						z_q <= z_q - sgma_pkg::atan_q30(step_q);
					end
					if (step_q < 5'd8) begin
						if (s_q >= sq_trial) begin
							s_q <= s_q - sq_trial;
							r_q <= (r_q >> 1) + sq_bit;
						end else begin
							r_q <= r_q >> 1;
						end
					end
					step_q <= step_q + 5'd1;
					if (step_q == 5'(sgma_pkg::CordicSteps - 1))
						state_q <= S_ROUND;
				end
				S_ROUND: begin
					res_mag_q <= (sat_q || r_q > 17'd255) ? 8'd255 : r_q[7:0];
					if (zero_q)
						res_dir_q <= 16'd0;
					else if (z_q[sgma_pkg::ZW-1])
						res_dir_q <= 16'(-z_rnd);
					else
						res_dir_q <= z_rnd[15:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {res_dir_q, res_mag_q};
						m_last_q  <= last_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/sgma_checker.sv
module sgma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// sequencer goes busy after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after accept");

	// a result is loaded only from a busy sequencer
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without work in flight");

	// magnitude zero implies direction zero
	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[7:0] == 8'd0 |-> m_axis_tdata[23:8] == 16'd0)
		else $error("direction without magnitude");

endmodule

bind sobel_gradient_magnitude_angle_unit sgma_checker u_sgma_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);
